[hw/rtl/safe_path_stream_checker_core_defines.svh]
// Assertion macros shared by the safe path checker RTL.
`ifndef SAFE_PATH_STREAM_CHECKER_CORE_DEFINES_SVH
`define SAFE_PATH_STREAM_CHECKER_CORE_DEFINES_SVH

// Property checked on clk, ignored while reset is asserted.
`define SPSC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property checked on clk at every edge, reset included.
`define SPSC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/spsc_pkg.sv]
// Shared constants and types for the safe path stream checker.
package spsc_pkg;

	// default COUNT_BITS; the saturating byte counter is one bit wider
	localparam int unsigned SPSC_COUNT_BITS = 16;

	localparam int unsigned MAX_LEN_W = 16;
	localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 16'hFFFF;

	// byte codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	// UTF-8 bounds
	localparam logic [7:0] U8_ASCII_TOP = 8'h7F;
	localparam logic [7:0] U8_CONT_LO   = 8'h80;
	localparam logic [7:0] U8_CONT_HI   = 8'hBF;
	localparam logic [7:0] U8_C1_HI     = 8'h9F;
	localparam logic [7:0] U8_LEAD2_LO  = 8'hC2;
	localparam logic [7:0] U8_LEAD2_HI  = 8'hDF;
	localparam logic [7:0] U8_LEAD3_LO  = 8'hE0;
	localparam logic [7:0] U8_LEAD_ED   = 8'hED;
	localparam logic [7:0] U8_LEAD3_HI  = 8'hEF;
	localparam logic [7:0] U8_LEAD4_LO  = 8'hF0;
	localparam logic [7:0] U8_LEAD4_HI  = 8'hF4;
	localparam logic [7:0] U8_E0_LO     = 8'hA0;
	localparam logic [7:0] U8_ED_HI     = 8'h9F;
	localparam logic [7:0] U8_F0_LO     = 8'h90;
	localparam logic [7:0] U8_F4_HI     = 8'h8F;

	// control from the path stage to the UTF-8 tracker
	typedef struct packed {
		logic step;   // a path byte is consumed this cycle
		logic clear;  // the path ends this cycle
	} spsc_utf8_ctrl_t;

	// status back from the UTF-8 tracker
	typedef struct packed {
		logic err;    // this byte breaks strict UTF-8 or is a C1 control
		logic open;   // a sequence stays open after this byte
	} spsc_utf8_stat_t;

endpackage

[hw/rtl/spsc_utf8.sv]
// Strict UTF-8 sequence tracker with C1 control detection.
`include "safe_path_stream_checker_core_defines.svh"

module spsc_utf8
	import spsc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  spsc_utf8_ctrl_t ctrl,
	input  logic [7:0]      byte_in,
	output spsc_utf8_stat_t stat
);

	logic [1:0] left_q;
	logic [7:0] lead_q;
	logic       second_q;

	logic [1:0] left_n;
	logic [7:0] lead_n;
	logic       second_n;
	logic [7:0] lo;
	logic [7:0] hi;
	logic       range_bad;
	logic       c1_hit;

	// next sequence state and per-byte error
	always_comb begin
		left_n    = left_q;
		lead_n    = lead_q;
		second_n  = second_q;
		lo        = U8_CONT_LO;
		hi        = U8_CONT_HI;
		range_bad = 1'b0;
		c1_hit    = 1'b0;
		stat.err  = 1'b0;
		if (left_q != 2'd0) begin
			if (second_q) begin
				if (lead_q == U8_LEAD3_LO)
					lo = U8_E0_LO;
				else if (lead_q == U8_LEAD_ED)
					hi = U8_ED_HI;
				else if (lead_q == U8_LEAD4_LO)
					lo = U8_F0_LO;
				else if (lead_q == U8_LEAD4_HI)
					hi = U8_F4_HI;
				c1_hit = (lead_q == U8_LEAD2_LO) && (byte_in <= U8_C1_HI);
			end
			range_bad = (byte_in < lo) || (byte_in > hi);
			stat.err  = c1_hit || range_bad;
			second_n  = 1'b0;
			left_n    = range_bad ? 2'd0 : left_q - 2'd1;
		end else if (byte_in > U8_ASCII_TOP) begin
			if (byte_in >= U8_LEAD2_LO && byte_in <= U8_LEAD2_HI) begin
				left_n   = 2'd1;
				lead_n   = byte_in;
				second_n = 1'b1;
			end else if (byte_in >= U8_LEAD3_LO && byte_in <= U8_LEAD3_HI) begin
				left_n   = 2'd2;
				lead_n   = byte_in;
				second_n = 1'b1;
			end else if (byte_in >= U8_LEAD4_LO && byte_in <= U8_LEAD4_HI) begin
				left_n   = 2'd3;
				lead_n   = byte_in;
				second_n = 1'b1;
			end else begin
				stat.err = 1'b1;
			end
		end
		stat.open = (left_n != 2'd0);
	end

	// sequence state; cleared when the path ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= 2'd0;
			lead_q   <= 8'h00;
			second_q <= 1'b0;
		end else if (ctrl.clear) begin
			left_q   <= 2'd0;
			lead_q   <= 8'h00;
			second_q <= 1'b0;
		end else if (ctrl.step) begin
			left_q   <= left_n;
			lead_q   <= lead_n;
			second_q <= second_n;
		end
	end

	`SPSC_ASSERT(a_second_needs_open, second_q |-> (left_q != 2'd0), "second-byte flag without open sequence")
	`SPSC_ASSERT(a_lead_is_valid, second_q |-> (lead_q >= U8_LEAD2_LO && lead_q <= U8_LEAD4_HI), "stored lead byte out of range")
	`SPSC_ASSERT(a_clear_closes, ctrl.clear |=> (left_q == 2'd0 && !second_q), "sequence open after path end")

endmodule

[hw/rtl/safe_path_stream_checker_core.sv]
// Top level of the safe relative path stream checker.
// Takes one path byte per cycle while in_stall is low and returns one
// accept/reject word per path. A path's last byte (or empty mark) goes into
// the input register when taken, and its verdict then goes into the result
// register that drives the outputs. The byte stage stalls only while it holds
// a path-ending byte and the result register is full and stalled. max_length
// may be written at any time the block is idle; cfg_ready is always high.
`include "safe_path_stream_checker_core_defines.svh"

module safe_path_stream_checker_core
	import spsc_pkg::*;
#(
	parameter int unsigned COUNT_BITS = SPSC_COUNT_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [MAX_LEN_W-1:0] max_length,
	// path bytes
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           byte_value,
	input  logic                 last,
	input  logic                 empty_path,
	// verdicts
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 accept
);

	localparam int unsigned CNT_W = COUNT_BITS + 1;
	localparam int unsigned CMP_W = (CNT_W > MAX_LEN_W) ? CNT_W : MAX_LEN_W;
	localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(1) << COUNT_BITS;

	logic [MAX_LEN_W-1:0] max_len_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       empty_s1;

	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       seg_len_q;
	logic             dots_q;
	logic             reject_q;

	logic             out_valid_q;
	logic             accept_q;

	logic             ends_s1;
	logic             out_free;
	logic             fire_s1;
	logic             in_take;
	logic [CNT_W-1:0] cnt_n;
	logic             cnt_over;
	logic             char_bad;
	logic             is_slash;
	logic             seg_bad_cur;
	logic [1:0]       seg_len_n;
	logic             dots_n;
	logic             seg_bad_end;
	logic             reject_n;
	logic             verdict;

	spsc_utf8_ctrl_t  utf_ctrl;
	spsc_utf8_stat_t  utf_stat;

	// config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= max_length;
		end
	end

	// flow control
	assign ends_s1  = last_s1 || empty_s1;
	assign out_free = !out_valid_q || !out_stall;
	assign fire_s1  = valid_s1 && (!ends_s1 || out_free);
	assign in_stall = valid_s1 && !fire_s1;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= byte_value;
			last_s1  <= last;
			empty_s1 <= empty_path;
		end
	end

	// per-byte checks
	always_comb begin
		cnt_n       = (cnt_q < CNT_SAT) ? cnt_q + CNT_W'(1) : cnt_q;
		cnt_over    = CMP_W'(cnt_n) > CMP_W'(max_len_q);
		char_bad    = (byte_s1 < CH_SPACE) || (byte_s1 == CH_DEL) ||
		              (byte_s1 == CH_BSLASH) || (byte_s1 == CH_COLON);
		is_slash    = (byte_s1 == CH_SLASH);
		seg_bad_cur = (seg_len_q == 2'd0) || (dots_q && seg_len_q <= 2'd2);
		if (is_slash) begin
			seg_len_n = 2'd0;
			dots_n    = 1'b1;
		end else begin
			seg_len_n = (seg_len_q == 2'd3) ? seg_len_q : seg_len_q + 2'd1;
			dots_n    = dots_q && (byte_s1 == CH_DOT);
		end
		seg_bad_end = (seg_len_n == 2'd0) || (dots_n && seg_len_n <= 2'd2);
		reject_n    = reject_q || cnt_over || char_bad || (is_slash && seg_bad_cur) ||
		              utf_stat.err;
		verdict     = !(reject_n || seg_bad_end || utf_stat.open);
	end

	assign utf_ctrl.step  = fire_s1 && !empty_s1;
	assign utf_ctrl.clear = fire_s1 && ends_s1;

	spsc_utf8 u_utf8 (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (utf_ctrl),
		.byte_in (byte_s1),
		.stat    (utf_stat)
	);

	// path state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			seg_len_q <= 2'd0;
			dots_q    <= 1'b1;
			reject_q  <= 1'b0;
		end else if (fire_s1) begin
			if (ends_s1) begin
				cnt_q     <= '0;
				seg_len_q <= 2'd0;
				dots_q    <= 1'b1;
				reject_q  <= 1'b0;
			end else begin
				cnt_q     <= cnt_n;
				seg_len_q <= seg_len_n;
				dots_q    <= dots_n;
				reject_q  <= reject_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && ends_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && ends_s1) begin
			accept_q <= empty_s1 ? 1'b0 : verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign accept    = accept_q;

	`SPSC_ASSERT(a_empty_rejects, (fire_s1 && empty_s1) |=> (out_valid_q && !accept_q), "empty accepted")
	`SPSC_ASSERT(a_end_clears, (fire_s1 && ends_s1) |=> (cnt_q == '0 && !reject_q && dots_q), "state kept")
	`SPSC_ASSERT(a_cnt_sat, cnt_q <= CNT_SAT, "byte counter past saturation")
	`SPSC_ASSERT(a_no_overwrite, (out_valid_q && out_stall) |-> !(fire_s1 && ends_s1), "overwrite")

endmodule

[bench/safe_path_stream_checker_core_tb.sv]
// Self-checking testbench for the safe path stream checker core.
module safe_path_stream_checker_core_tb;
	import spsc_pkg::*;

	localparam int unsigned COUNT_BITS = SPSC_COUNT_BITS;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_WORDS = 75;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [MAX_LEN_W-1:0] max_length = MAX_LEN_RESET;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] byte_value = 8'h00;
	logic last = 1'b0;
	logic empty_path = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic accept;

	safe_path_stream_checker_core #(.COUNT_BITS(COUNT_BITS)) dut (
		.clk,
		.arst_n,
		.cfg_valid,
		.cfg_ready,
		.max_length,
		.in_valid,
		.in_stall,
		.byte_value,
		.last,
		.empty_path,
		.out_valid,
		.out_stall,
		.accept
	);

	// path checker state mirrored by the bench
	logic [MAX_LEN_W-1:0] len_limit = MAX_LEN_RESET;
	longint unsigned path_bytes;
	logic [1:0] seg_len;
	logic seg_dots;
	logic path_bad;
	logic [1:0] cont_left;
	logic [7:0] lead;
	logic second_due;
	logic verdicts_due[$];

	// bytes of the path being generated
	logic [7:0] path_buf[$];

	int idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int verdicts_seen = 0;
	int accepts_seen = 0;
	int words_sent = 0;
	int limits_written = 0;
	int quiet_cycles = 0;
	logic want_accept;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void restart_path();
		path_bytes = 0;
		seg_len = 2'd0;
		seg_dots = 1'b1;
		path_bad = 1'b0;
		cont_left = 2'd0;
		lead = 8'h00;
		second_due = 1'b0;
	endfunction

	// empty, "." or ".." segment
	function automatic logic segment_void();
		return seg_len == 2'd0 || (seg_dots && seg_len <= 2'd2);
	endfunction

	// advance the mirrored state by one accepted word, queue a verdict if the path ends
	task automatic judge_word(input logic [7:0] b, input logic l, input logic e);
		logic [7:0] lo;
		logic [7:0] hi;
		if (e) begin
			verdicts_due.push_back(1'b0);
			restart_path();
		end else begin
			if (path_bytes < (64'd1 << COUNT_BITS))
				path_bytes++;
			if (path_bytes > 64'(len_limit))
				path_bad = 1'b1;
			if (b < CH_SPACE || b == CH_DEL || b == CH_BSLASH || b == CH_COLON)
				path_bad = 1'b1;

			// segment tracking
			if (b == CH_SLASH) begin
				if (segment_void())
					path_bad = 1'b1;
				seg_len = 2'd0;
				seg_dots = 1'b1;
			end else begin
				if (seg_len != 2'd3)
					seg_len++;
				if (b != CH_DOT)
					seg_dots = 1'b0;
			end

			// strict UTF-8
			if (cont_left != 2'd0) begin
				lo = U8_CONT_LO;
				hi = U8_CONT_HI;
				if (second_due) begin
					if (lead == U8_LEAD3_LO)
						lo = U8_E0_LO;
					else if (lead == U8_LEAD_ED)
						hi = U8_ED_HI;
					else if (lead == U8_LEAD4_LO)
						lo = U8_F0_LO;
					else if (lead == U8_LEAD4_HI)
						hi = U8_F4_HI;
					// C1 control code point
					if (lead == U8_LEAD2_LO && b <= U8_C1_HI)
						path_bad = 1'b1;
				end
				second_due = 1'b0;
				if (b < lo || b > hi) begin
					path_bad = 1'b1;
					cont_left = 2'd0;
				end else begin
					cont_left--;
				end
			end else if (b > U8_ASCII_TOP) begin
				if (b >= U8_LEAD2_LO && b <= U8_LEAD2_HI)
					cont_left = 2'd1;
				else if (b >= U8_LEAD3_LO && b <= U8_LEAD3_HI)
					cont_left = 2'd2;
				else if (b >= U8_LEAD4_LO && b <= U8_LEAD4_HI)
					cont_left = 2'd3;
				else
					path_bad = 1'b1;
				if (cont_left != 2'd0) begin
					lead = b;
					second_due = 1'b1;
				end
			end

			if (l) begin
				if (segment_void() || cont_left != 2'd0)
					path_bad = 1'b1;
				verdicts_due.push_back(!path_bad);
				restart_path();
			end
		end
	endtask

	// send one word, with random idle cycles first; valid stays high afterwards
	task automatic send_word(input logic [7:0] b, input logic l, input logic e);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		byte_value <= b;
		last <= l;
		empty_path <= e;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		judge_word(b, l, e);
		words_sent++;
	endtask

	// wait until every verdict is in and the pipeline has emptied
	task automatic drain();
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [MAX_LEN_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		max_length <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		len_limit = v;
		limits_written++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], i == s.len() - 1, 1'b0);
	endtask

	// n bytes packed most significant first
	task automatic send_seq(input int n, input logic [31:0] seq);
		for (int i = n - 1; i >= 0; i--)
			send_word(seq[8*i +: 8], i == 0, 1'b0);
	endtask

	task automatic send_long(input int n);
		for (int i = 0; i < n; i++)
			send_word("a", i == n - 1, 1'b0);
	endtask

	// one character: mostly printable ASCII or well-formed UTF-8, sometimes any byte
	task automatic push_char();
		int unsigned pick;
		int tail;
		logic [7:0] b;
		logic [7:0] lo;
		logic [7:0] hi;
		pick = $urandom_range(99);
		if (pick < 55) begin
			b = 8'($urandom_range(8'h7E, 8'h20));
			if (b == CH_SLASH || b == CH_BSLASH || b == CH_COLON)
				b = "x";
			path_buf.push_back(b);
		end else if (pick < 90) begin
			if (pick < 70) begin
				tail = 1;
				b = 8'($urandom_range(U8_LEAD2_HI, U8_LEAD2_LO));
			end else if (pick < 82) begin
				tail = 2;
				b = 8'($urandom_range(U8_LEAD3_HI, U8_LEAD3_LO));
			end else begin
				tail = 3;
				b = 8'($urandom_range(U8_LEAD4_HI, U8_LEAD4_LO));
			end
			lo = U8_CONT_LO;
			hi = U8_CONT_HI;
			if (b == U8_LEAD3_LO)
				lo = U8_E0_LO;
			else if (b == U8_LEAD_ED)
				hi = U8_ED_HI;
			else if (b == U8_LEAD4_LO)
				lo = U8_F0_LO;
			else if (b == U8_LEAD4_HI)
				hi = U8_F4_HI;
			path_buf.push_back(b);
			path_buf.push_back(8'($urandom_range(hi, lo)));
			repeat (tail - 1)
				path_buf.push_back(8'($urandom_range(U8_CONT_HI, U8_CONT_LO)));
		end else begin
			path_buf.push_back(8'($urandom_range(255)));
		end
	endtask

	// random path of one to three segments, with occasional bad segments and slashes
	task automatic build_path();
		int segs;
		path_buf.delete();
		if ($urandom_range(15) == 0)
			path_buf.push_back(CH_SLASH);
		segs = $urandom_range(3, 1);
		for (int s = 0; s < segs; s++) begin
			if (s != 0)
				path_buf.push_back(CH_SLASH);
			case ($urandom_range(19))
				0: ;
				1: path_buf.push_back(CH_DOT);
				2: repeat (2) path_buf.push_back(CH_DOT);
				3: repeat (3) path_buf.push_back(CH_DOT);
				4: begin
					path_buf.push_back(CH_DOT);
					push_char();
				end
				default: repeat ($urandom_range(4, 1)) push_char();
			endcase
		end
		if ($urandom_range(15) == 0)
			path_buf.push_back(CH_SLASH);
		if (path_buf.size() == 0)
			push_char();
	endtask

	// send a random path, now and then cut short by an empty mark
	task automatic send_random_path();
		int n;
		int cut;
		build_path();
		n = path_buf.size();
		cut = (n > 1 && $urandom_range(19) == 0) ? $urandom_range(n - 1, 1) : 0;
		for (int i = 0; i < (cut != 0 ? cut : n); i++)
			send_word(path_buf[i], i == n - 1, 1'b0);
		if (cut != 0)
			send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
	endtask

	task automatic test_path_rules();
		send_word(8'hFF, 1'b0, 1'b1);   // empty path
		send_word("a", 1'b1, 1'b1);     // empty mark wins over last
		send_text("a");
		send_text("/a");
		send_text("a/");
		send_text(".");
		send_text("..");
		send_text("...");
		send_text("a:b");
		send_text("a\\b");
		send_text(":a");                // later bytes cannot clear a failure
		send_seq(1, 32'h00);
		send_seq(1, 32'h1F);
		send_seq(1, 32'h7F);
		send_seq(1, 32'h20);
		// empty mark after bytes aborts the path
		send_word("a", 1'b0, 1'b0);
		send_word(8'h00, 1'b1, 1'b1);
	endtask

	task automatic test_utf8_rules();
		send_seq(2, 32'hC2A0);
		send_seq(2, 32'hC280);          // C1 control
		send_seq(2, 32'hDFBF);
		send_seq(3, 32'hE0A080);
		send_seq(3, 32'hE09F80);        // overlong
		send_seq(3, 32'hED9FBF);
		send_seq(3, 32'hEDA080);        // surrogate
		send_seq(4, 32'hF0908080);
		send_seq(4, 32'hF08F8080);      // overlong
		send_seq(4, 32'hF48FBFBF);
		send_seq(4, 32'hF4908080);      // above U+10FFFF
		send_seq(1, 32'hF5);
		send_seq(1, 32'hC1);
		send_seq(1, 32'h80);            // stray continuation
		send_seq(1, 32'hC3);            // truncated
		send_seq(3, 32'hE28261);        // broken continuation
	endtask

	task automatic test_length_limits();
		write_limit(16'h0000);
		send_text("a");
		write_limit(16'd2);
		send_text("ab");
		send_text("abc");
		write_limit(16'd20);
		send_long(20);                  // exactly at the limit
		send_long(21);                  // one byte over
		write_limit(MAX_LEN_RESET);
		drain();
	endtask

	task automatic test_random_paths(input int send_idle, input int recv_stall,
			input logic [MAX_LEN_W-1:0] limit);
		int first;
		write_limit(limit);
		idle_pct = send_idle;
		stall_pct = recv_stall;
		first = words_sent;
		while (words_sent - first < PHASE_WORDS) begin
			if ($urandom_range(24) == 0)
				send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
			else
				send_random_path();
		end
		drain();
	endtask

	// verdict checker and receiver stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			verdicts_seen++;
			if (accept)
				accepts_seen++;
			if (verdicts_due.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected verdict accept=%0d at %0t", accept, $realtime);
				mismatches++;
			end else begin
				want_accept = verdicts_due.pop_front();
				if (accept !== want_accept) begin
					if (mismatches < 10)
						$display("verdict %0d: expected accept=%0d, got %0d",
							verdicts_seen, want_accept, accept);
					mismatches++;
				end
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("no handshake for %0d cycles", QUIET_LIMIT);
			$display("safe_path_stream_checker_core_tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		restart_path();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_path_rules();
		test_utf8_rules();
		test_length_limits();
		test_random_paths(0, 0, MAX_LEN_RESET);
		test_random_paths(72, 0, 16'($urandom_range(24, 4)));
		test_random_paths(0, 72, 16'd8);
		test_random_paths(36, 36, 16'($urandom_range(65535, 16)));
		drain();

		$display("%0d verdicts checked (%0d accepts) from %0d words",
			verdicts_seen, accepts_seen, words_sent);
		$display("%0d limits written, %0d mismatches", limits_written, mismatches);
		$display("path and UTF-8 rules, configured length limits, random paths under four idle/stall mixes");
		if (mismatches == 0 && verdicts_due.size() == 0)
			$display("safe_path_stream_checker_core_tb passed");
		else
			$display("safe_path_stream_checker_core_tb failed");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/spsc_pkg.sv
hw/rtl/spsc_utf8.sv
hw/rtl/safe_path_stream_checker_core.sv
bench/safe_path_stream_checker_core_tb.sv
